[hw/rtl/snt_pkg.sv]
// Shared types, codes and helpers for the strongest network table.
// Used by snt_seq, strongest_network_table and the testbench; no dependencies.
package snt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int NAME_BYTES        = 32;
  localparam int NAME_W            = NAME_BYTES * 8;

  localparam logic [1:0] MODE_REPORT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [3:0] STAT_IGNORED  = 4'd0;
  localparam logic [3:0] STAT_UPDATED  = 4'd1;
  localparam logic [3:0] STAT_KEPT     = 4'd2;
  localparam logic [3:0] STAT_APPENDED = 4'd3;
  localparam logic [3:0] STAT_REPLACED = 4'd4;
  localparam logic [3:0] STAT_DROPPED  = 4'd5;
  localparam logic [3:0] STAT_READ_OK  = 4'd6;
  localparam logic [3:0] STAT_RANGE    = 4'd7;
  localparam logic [3:0] STAT_CLEARED  = 4'd8;

  typedef logic [NAME_W-1:0] name_t;

  typedef struct packed {
    logic [7:0]  sec;
    logic [47:0] addr;
    logic [7:0]  chan;
    logic [7:0]  sig;
    logic [5:0]  len;
    name_t       name;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] read_index;
    rec_t       rec;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] slot;
    logic [4:0] count;
    rec_t       rec;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_RWAIT,
    S_DONE
  } seq_state_t;

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic [5:0] clip_len(input logic [7:0] l);
    return (l > 8'(NAME_BYTES)) ? 6'(NAME_BYTES) : l[5:0];
  endfunction

  function automatic name_t mask_name(input name_t n, input logic [5:0] len);
    name_t m;
    m = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (6'(b) < len) m[8*b +: 8] = n[8*b +: 8];
    end
    return m;
  endfunction

endpackage

[hw/rtl/snt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module snt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[hw/rtl/snt_seq.sv]
// Sequencer: holds the request, scans the record RAM for a name match and the
// weakest entry, writes back, and builds the result word. Depends on snt_pkg.
module snt_seq #(
  parameter int TABLE_ENTRIES = snt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  snt_pkg::req_t                                 in_req,
  output logic                                          res_valid,
  input  logic                                          res_ready,
  output snt_pkg::res_t                                 res,
  output logic                                          ram_we,
  output logic [snt_pkg::idx_width(TABLE_ENTRIES)-1:0]  ram_waddr,
  output snt_pkg::rec_t                                 ram_wdata,
  output logic                                          ram_re,
  output logic [snt_pkg::idx_width(TABLE_ENTRIES)-1:0]  ram_raddr,
  input  snt_pkg::rec_t                                 ram_rdata
);
  import snt_pkg::*;

  localparam int IDX_W = idx_width(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  seq_state_t       state_r, state_nxt;
  req_t             req_r, req_nxt;
  res_t             res_r, res_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] weak_idx_r, weak_idx_nxt;
  logic [7:0]       weak_sig_r, weak_sig_nxt;

  logic       accept, hit, stronger_hit, stronger_weak, scan_end, full, in_cnt_ok;
  logic [7:0] cmp8, weak8, cnt8, cnt_inc8, in_ridx8, req_ridx8;

  assign accept        = in_valid && in_ready;
  assign in_ready      = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res           = res_r;
  assign ram_wdata     = req_r.rec;

  assign cmp8          = 8'(cmp_idx_r);
  assign weak8         = 8'(weak_idx_r);
  assign cnt8          = 8'(count_r);
  assign cnt_inc8      = cnt8 + 8'd1;
  assign in_ridx8      = 8'(in_req.read_index);
  assign req_ridx8     = 8'(req_r.read_index);
  assign in_cnt_ok     = in_ridx8 < cnt8;

  assign hit           = cmp_vld_r && (ram_rdata.len == req_r.rec.len) &&
                         (ram_rdata.name == req_r.rec.name);
  assign stronger_hit  = $signed(req_r.rec.sig) > $signed(ram_rdata.sig);
  assign stronger_weak = $signed(req_r.rec.sig) > $signed(weak_sig_r);
  assign scan_end      = !cmp_vld_r && !(rd_ptr_r < count_r);
  assign full          = (count_r == CNT_W'(TABLE_ENTRIES));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req.mode)
            MODE_REPORT: state_nxt = (in_req.rec.len == '0) ? S_DONE : S_SCAN;
            MODE_READ:   state_nxt = in_cnt_ok ? S_READ : S_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN:  if (hit || scan_end) state_nxt = S_DONE;
      S_READ:  state_nxt = S_RWAIT;
      S_RWAIT: state_nxt = S_DONE;
      S_DONE:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req_nxt      = req_r;
    res_nxt      = res_r;
    count_nxt    = count_r;
    rd_ptr_nxt   = rd_ptr_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    weak_idx_nxt = weak_idx_r;
    weak_sig_nxt = weak_sig_r;
    ram_we       = 1'b0;
    ram_waddr    = cmp_idx_r;
    ram_re       = 1'b0;
    ram_raddr    = rd_ptr_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt       = in_req;
          rd_ptr_nxt    = '0;
          res_nxt       = '0;
          res_nxt.count = cnt8[4:0];
          case (in_req.mode)
            MODE_REPORT: res_nxt.status = STAT_IGNORED;
            MODE_READ:   res_nxt.status = in_cnt_ok ? STAT_READ_OK : STAT_RANGE;
            MODE_CLEAR: begin
              count_nxt      = '0;
              res_nxt.count  = '0;
              res_nxt.status = STAT_CLEARED;
            end
            default:     res_nxt.status = STAT_IGNORED;
          endcase
        end
      end
      S_SCAN: begin
        if ((rd_ptr_r < count_r) && !hit) begin
          ram_re      = 1'b1;
          ram_raddr   = rd_ptr_r[IDX_W-1:0];
          rd_ptr_nxt  = rd_ptr_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_ptr_r[IDX_W-1:0];
        end
        if (cmp_vld_r) begin
          if ((cmp_idx_r == '0) || ($signed(ram_rdata.sig) < $signed(weak_sig_r))) begin
            weak_idx_nxt = cmp_idx_r;
            weak_sig_nxt = ram_rdata.sig;
          end
        end
        if (hit) begin
          res_nxt.slot = cmp8[3:0];
          if (stronger_hit) begin
            ram_we         = 1'b1;
            ram_waddr      = cmp_idx_r;
            res_nxt.status = STAT_UPDATED;
          end else begin
            res_nxt.status = STAT_KEPT;
          end
        end else if (scan_end) begin
          if (!full) begin
            ram_we         = 1'b1;
            ram_waddr      = cnt8[IDX_W-1:0];
            count_nxt      = count_r + CNT_W'(1);
            res_nxt.status = STAT_APPENDED;
            res_nxt.slot   = cnt8[3:0];
            res_nxt.count  = cnt_inc8[4:0];
          end else if (stronger_weak) begin
            ram_we         = 1'b1;
            ram_waddr      = weak_idx_r;
            res_nxt.status = STAT_REPLACED;
            res_nxt.slot   = weak8[3:0];
          end else begin
            res_nxt.status = STAT_DROPPED;
          end
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = req_ridx8[IDX_W-1:0];
      end
      S_RWAIT: begin
        res_nxt.status = STAT_READ_OK;
        res_nxt.slot   = req_r.read_index;
        res_nxt.rec    = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    weak_idx_r <= weak_idx_nxt;
    weak_sig_r <= weak_sig_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN))
    else $error("table write outside scan");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !hit && scan_end && !full) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not grow count");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |-> (cmp8 < cnt8))
    else $error("match on entry beyond count");
`endif

endmodule

[hw/rtl/strongest_network_table.sv]
// Strongest network table, top level: stream ports, record RAM, sequencer and
// output register. Depends on snt_pkg, snt_ram and snt_seq.
//
// Usage:
//   in_* carries one request word; in_tuser is the mode (report, read, clear).
//   out_* carries one result word per request; out_tuser is the status code.
//   A report is matched by clipped name against the stored records, one RAM
//   read per cycle; it updates the match if stronger, else appends, else
//   replaces the weakest record if stronger.
//   A report reads the stored entries one by one and compares each, then
//   decides and writes back; an early match ends the scan sooner, and an empty
//   table goes straight to the decision. A read passes S_READ and S_RWAIT;
//   clear, ignored and out-of-range requests go straight to the result.
//   The sequential scan through the single record RAM read port sets the rate.
//   One request is in work at a time; the next is taken the cycle after the
//   previous result enters the output register, even while the receiver has
//   not taken it.
//   Reset empties the table (count to zero); RAM contents are not cleared.
//   When out_tready is low the result holds in the output register and the
//   sequencer waits with the next result until the register frees up.
module strongest_network_table #(
  parameter int TABLE_ENTRIES = snt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [255:0] name_word0..3, [263:256] name_length, [271:264] signal_level,
  // [279:272] radio_channel, [327:280] station_address,
  // [335:328] security_mode, [339:336] read_index, [343:340] zero
  input  logic [343:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] slot, [8:4] entry_count, [264:9] out_name_word0..3,
  // [270:265] out_name_length, [278:271] out_signal, [286:279] out_channel,
  // [334:287] out_address, [342:335] out_security, [343] zero
  output logic [343:0] out_tdata,
  // [3:0] status
  output logic [3:0]   out_tuser
);
  import snt_pkg::*;

  localparam int IDX_W = idx_width(TABLE_ENTRIES);

  req_t             in_req;
  res_t             seq_res, out_res_r;
  logic             res_valid, res_ready, out_tvalid_r;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  rec_t             ram_wdata, ram_rdata;
  logic [REC_W-1:0] ram_rvec;
  logic [5:0]       len_c;

  assign len_c              = clip_len(in_tdata[263:256]);
  assign in_req.mode        = in_tuser;
  assign in_req.read_index  = in_tdata[339:336];
  assign in_req.rec.name    = mask_name(in_tdata[255:0], len_c);
  assign in_req.rec.len     = len_c;
  assign in_req.rec.sig     = in_tdata[271:264];
  assign in_req.rec.chan    = in_tdata[279:272];
  assign in_req.rec.addr    = in_tdata[327:280];
  assign in_req.rec.sec     = in_tdata[335:328];

  assign ram_rdata = rec_t'(ram_rvec);

  snt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rvec)
  );

  snt_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (seq_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= seq_res;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.rec.sec, out_res_r.rec.addr, out_res_r.rec.chan,
                       out_res_r.rec.sig, out_res_r.rec.len, out_res_r.rec.name,
                       out_res_r.count, out_res_r.slot};

endmodule

[tb/snt_result_checker.sv]
// Result checker for strongest_network_table: keeps its own copy of the table,
// predicts one result word per accepted request word and compares the fields.
// Depends on snt_pkg for the record layout and the mode and status codes.
module snt_result_checker
  import snt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic [343:0]    in_tdata,
  input  logic [1:0]      in_tuser,
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [343:0]    out_tdata,
  input  logic [3:0]      out_tuser,
  output int unsigned     errors,
  output int unsigned     pending,
  output int unsigned     results_checked,
  output logic [8:0]      codes_seen
);

  localparam int DEPTH = TABLE_ENTRIES_DEF;

  rec_t        entries [DEPTH];
  int unsigned entry_count;
  res_t        expected_results [$];
  res_t        want_now;
  res_t        want;
  res_t        got;

  initial begin
    errors          = 0;
    pending         = 0;
    results_checked = 0;
    codes_seen      = '0;
    entry_count     = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    errors++;
    if (errors <= 50)
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got_v, want_v);
  endtask

  task automatic check_field(input string what, input logic [63:0] got_v,
                             input logic [63:0] want_v);
    if (got_v !== want_v) report_mismatch(what, got_v, want_v);
  endtask

  // One request word against the table copy; returns the result word it must give.
  task automatic table_step(input logic [1:0] mode, input logic [343:0] d,
                            output res_t r);
    name_t             nm;
    logic [5:0]        len;
    logic signed [7:0] sig;
    rec_t              incoming;
    int                hit;
    int                weak_i;
    logic [3:0]        idx;
    r = '0;
    r.status = STAT_IGNORED;
    case (mode)
      MODE_REPORT: begin
        len = (d[263:256] > 8'(NAME_BYTES)) ? 6'(NAME_BYTES) : d[261:256];
        nm = '0;
        for (int b = 0; b < NAME_BYTES; b++)
          if (b < len) nm[8*b +: 8] = d[8*b +: 8];
        sig           = d[271:264];
        incoming.name = nm;
        incoming.len  = len;
        incoming.sig  = d[271:264];
        incoming.chan = d[279:272];
        incoming.addr = d[327:280];
        incoming.sec  = d[335:328];
        hit = -1;
        if (len != 0) begin
          for (int i = 0; i < entry_count; i++)
            if (hit < 0 && entries[i].len == len && entries[i].name == nm) hit = i;
          if (hit >= 0) begin
            r.slot = 4'(hit);
            if (sig > $signed(entries[hit].sig)) begin
              entries[hit] = incoming;
              r.status = STAT_UPDATED;
            end else begin
              r.status = STAT_KEPT;
            end
          end else if (entry_count < DEPTH) begin
            r.slot = 4'(entry_count);
            entries[entry_count] = incoming;
            entry_count++;
            r.status = STAT_APPENDED;
          end else begin
            weak_i = 0;
            for (int i = 1; i < DEPTH; i++)
              if ($signed(entries[i].sig) < $signed(entries[weak_i].sig)) weak_i = i;
            if (sig > $signed(entries[weak_i].sig)) begin
              entries[weak_i] = incoming;
              r.slot = 4'(weak_i);
              r.status = STAT_REPLACED;
            end else begin
              r.status = STAT_DROPPED;
            end
          end
        end
      end
      MODE_READ: begin
        idx = d[339:336];
        if (idx < entry_count) begin
          r.status = STAT_READ_OK;
          r.slot   = idx;
          r.rec    = entries[idx];
        end else begin
          r.status = STAT_RANGE;
        end
      end
      MODE_CLEAR: begin
        entry_count = 0;
        r.status = STAT_CLEARED;
      end
      default: r.status = STAT_IGNORED;
    endcase
    r.count = 5'(entry_count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      entry_count = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        table_step(in_tuser, in_tdata, want_now);
        expected_results.push_back(want_now);
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.slot   = out_tdata[3:0];
        got.count  = out_tdata[8:4];
        got.rec    = out_tdata[342:9];
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected, status", 64'(got.status),
                          64'd0);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(got.status), 64'(want.status));
          check_field("slot", 64'(got.slot), 64'(want.slot));
          check_field("entry count", 64'(got.count), 64'(want.count));
          for (int w = 0; w < 4; w++)
            check_field($sformatf("name word %0d", w), got.rec.name[64*w +: 64],
                        want.rec.name[64*w +: 64]);
          check_field("name length", 64'(got.rec.len), 64'(want.rec.len));
          check_field("signal", 64'(got.rec.sig), 64'(want.rec.sig));
          check_field("channel", 64'(got.rec.chan), 64'(want.rec.chan));
          check_field("address", 64'(got.rec.addr), 64'(want.rec.addr));
          check_field("security", 64'(got.rec.sec), 64'(want.rec.sec));
          codes_seen[want.status] = 1'b1;
          results_checked++;
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/tb_strongest_network_table.sv]
// Testbench top for strongest_network_table: clock, reset, request stimulus and
// result back-pressure, verdict. Depends on snt_pkg and snt_result_checker.
module tb_strongest_network_table;
  import snt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         POOL        = 24;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [343:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = MODE_REPORT;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [343:0] out_tdata;
  logic [3:0]   out_tuser;

  int unsigned errors;
  int unsigned pending;
  int unsigned results_checked;
  logic [8:0]  codes_seen;

  int          tx_idle_pct  = 26;
  int          rx_stall_pct = 59;
  int unsigned sent         = 0;

  name_t pool_name [POOL];
  int    pool_len  [POOL];

  always #10 clk = ~clk;

  strongest_network_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  snt_result_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .errors          (errors),
    .pending         (pending),
    .results_checked (results_checked),
    .codes_seen      (codes_seen)
  );

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic name_t random_name();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  // bytes past the length carry noise; the block must ignore them
  function automatic name_t with_junk(input name_t n, input int len);
    for (int b = 0; b < NAME_BYTES; b++)
      if (b >= len) n[8*b +: 8] = 8'($urandom);
    return n;
  endfunction

  // each cycle before a word goes out, the sender idles with tx_idle_pct odds
  task automatic send_word(input logic [1:0] mode, input logic [343:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_report(input name_t nm, input logic [7:0] len, input int sig,
                             input logic [7:0] chan, input logic [47:0] addr,
                             input logic [7:0] sec);
    send_word(MODE_REPORT, {4'b0, 4'($urandom), sec, addr, chan, 8'(sig), len,
                            with_junk(nm, len)});
  endtask

  task automatic send_read(input logic [3:0] idx);
    send_word(MODE_READ, {4'b0, idx, 8'($urandom), 48'({$urandom, $urandom}),
                          8'($urandom), 8'($urandom), 8'($urandom), random_name()});
  endtask

  task automatic send_other(input logic [1:0] mode);
    send_word(mode, {4'b0, 4'($urandom), 8'($urandom), 48'({$urandom, $urandom}),
                     8'($urandom), 8'($urandom), 8'($urandom), random_name()});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly reports drawn from a small name pool so that matches, a full
  // table, replacements and drops all occur; clears are rare
  task automatic random_traffic(input int n);
    int    counted;
    int    p;
    int    q;
    int    k;
    int    len;
    name_t nm;
    counted = 0;
    while (counted < n) begin
      p = $urandom_range(99);
      if (p < 1) begin
        send_other(MODE_CLEAR);
        counted++;
      end else if (p < 3) begin
        send_other(MODE_UNUSED);
        counted++;
      end else if (p < 18) begin
        send_read(4'($urandom_range(15)));
        counted++;
      end else begin
        q = $urandom_range(99);
        if (q < 4) begin
          send_report(random_name(), 8'd0, $urandom_range(255), 8'($urandom),
                      48'({$urandom, $urandom}), 8'($urandom));
          counted++;
        end else begin
          if (q < 14) begin
            nm  = random_name();
            len = $urandom_range(1, 255);
          end else begin
            k = $urandom_range(POOL - 1);
            if ($urandom_range(49) == 0) begin
              pool_name[k] = random_name();
              pool_len[k]  = $urandom_range(1, NAME_BYTES);
            end
            nm  = pool_name[k];
            len = pool_len[k];
            if (len == NAME_BYTES && $urandom_range(1) == 1) len = $urandom_range(33, 255);
          end
          send_report(nm, 8'(len), $urandom_range(255), 8'($urandom),
                      48'({$urandom, $urandom}), 8'($urandom));
          counted++;
        end
      end
    end
  endtask

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    name_t nm_a;
    name_t nm_b;
    name_t nm;
    for (int i = 0; i < POOL; i++) begin
      pool_name[i] = random_name();
      pool_len[i]  = $urandom_range(1, NAME_BYTES);
    end
    nm_a = random_name();
    nm_b = random_name();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: hidden name, match rules, clipping, reads, full table
    send_report(random_name(), 8'd0, 127, 8'hff, 48'hffff_ffff_ffff, 8'hff);
    send_report(nm_a, 8'd5, -50, 8'h00, 48'h0, 8'h00);
    send_report(nm_a, 8'd5, -60, 8'h11, 48'h1, 8'h01);
    send_report(nm_a, 8'd5, -20, 8'hff, 48'hffff_ffff_ffff, 8'hff);
    send_report(nm_a, 8'd6, 127, 8'h01, 48'h8000_0000_0000, 8'h80);
    send_report(nm_b, 8'd255, -128, 8'h80, 48'h0000_0000_0001, 8'h7f);
    send_report(nm_b, 8'd32, 127, 8'h7f, 48'h7fff_ffff_ffff, 8'h00);
    send_report(nm_b, 8'd33, 127, 8'h00, 48'h0, 8'hff);
    send_other(MODE_UNUSED);
    send_read(4'd0);
    send_read(4'd15);
    for (int k = 3; k < TABLE_ENTRIES_DEF; k++) begin
      nm = random_name();
      nm[7:0] = 8'hA0 + 8'(k);
      send_report(nm, 8'($urandom_range(1, NAME_BYTES)),
                  (k == 6 || k == 11) ? -120 : -100 + k, 8'($urandom),
                  48'({$urandom, $urandom}), 8'($urandom));
    end
    send_report(random_name(), 8'd32, -120, 8'h00, 48'h0, 8'h00);
    send_report(random_name(), 8'd20, -119, 8'hff, 48'hffff_ffff_ffff, 8'hff);
    send_read(4'd6);
    send_other(MODE_CLEAR);
    send_read(4'd0);

    random_traffic(300);

    tx_idle_pct  = 59;
    rx_stall_pct <= 26;
    random_traffic(160);
    drain();
    random_traffic(150);

    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    random_traffic(320);

    drain();
    repeat (25) @(posedge clk);
    $display("Run covered %0d request words and %0d result words; status codes hit (8..0): %b",
             sent, results_checked, codes_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/snt_pkg.sv
hw/rtl/snt_ram.sv
hw/rtl/snt_seq.sv
hw/rtl/strongest_network_table.sv
tb/snt_result_checker.sv
tb/tb_strongest_network_table.sv
